FILE: hw/rtl/bsvn_pkg.sv
// shared types and constants of the batched state vector normalizer
// no dependencies
package bsvn_pkg;

  // status codes on the result channel
  localparam logic [1:0] StatusPoint = 2'd0;
  localparam logic [1:0] StatusNorm  = 2'd1;
  localparam logic [1:0] StatusZero  = 2'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_COMPLEX_MODE = 2'd0,
    CFG_VOLUME       = 2'd1,
    CFG_STATES       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        complex_mode;
    logic [31:0] volume_element;
    logic [15:0] states_in_batch;
  } cfg_t;

  // one classified input item
  typedef struct packed {
    logic        is_scale;
    logic        last;
    logic [31:0] re;
    logic [31:0] im;
  } item_t;

  typedef struct packed {
    logic [31:0] out_real;
    logic [31:0] out_imag;
    logic [63:0] norm_integral;
    logic [1:0]  status;
    logic        point_last;
    logic        batch_end;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_POST,
    ST_VLO,
    ST_VHI,
    ST_VSUM,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } back_st_e;

endpackage

FILE: hw/rtl/bsvn_front.sv
// front part: takes input transfers, classifies them and queues them
// depends on bsvn_pkg
module bsvn_front
  import bsvn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic        last_i,
  input  logic [63:0] data_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      in_item;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    in_item.is_scale = req_type_i;
    in_item.last     = last_i;
    in_item.re       = data_i[31:0];
    in_item.im       = data_i[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_item;
  end

endmodule

FILE: hw/rtl/bsvn_back.sv
// back part: squares and sums, norm, inverse square root, scaling, output register
// depends on bsvn_pkg
module bsvn_back
  import bsvn_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int ACC_WIDTH    = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int SwEff    = (SAMPLE_WIDTH < 32) ? SAMPLE_WIDTH : 32;
  localparam int FracBits = SwEff - 8;
  localparam int DivExp   = 2 * FracBits + 48;
  localparam int DivSteps = DivExp + 1;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int ProdW    = 32 + SwEff;
  localparam logic [63:0] AccMax = 64'({ACC_WIDTH{1'b1}});
  localparam logic [63:0] PosLim = 64'((64'd1 << (SwEff - 1)) - 64'd1);
  localparam logic [63:0] NegLim = 64'(64'd1 << (SwEff - 1));

  back_st_e state_q, state_d;

  item_t                 wk_q;
  logic [ACC_WIDTH-1:0]  sum_q;
  logic [31:0]           sf_q;
  logic                  zero_seen_q;
  logic [15:0]           idx_q;
  logic [ProdW-1:0]      prod_re_q, prod_im_q;
  logic [63:0]           vlo_q, vhi_q, norm_q;
  logic [63:0]           rem_q, quo_q, x_q, res_q, bit_q;
  logic                  over_q;
  logic [DivCntW-1:0]    dcnt_q;
  logic [4:0]            scnt_q;
  result_t               stage_q;
  result_t               out_q;
  logic                  out_valid_q;

  // magnitudes of the held item
  logic [SwEff-1:0] raw_re, raw_im, mag_re, mag_im;
  logic             neg_re, neg_im;
  logic [31:0]      mul_b_re, mul_b_im;
  logic [63:0]      sum64;
  logic [31:0]      vol_a;
  logic [63:0]      vol_prod;
  logic [65:0]      acc_tot;
  logic [ACC_WIDTH-1:0] acc_next;
  logic [64:0]      norm_sum;
  logic [63:0]      norm_val;
  logic             rem_carry, rem_take;
  logic [63:0]      rem_sh, rem_next, quo_next;
  logic [63:0]      sq_try, x_next, res_next;
  logic             sq_take;
  logic [31:0]      sf_final;
  logic [63:0]      p_re, p_im;
  logic [31:0]      scaled_re, scaled_im;
  logic [15:0]      idx_top;
  logic             slot_free;
  result_t          point_res, norm_res, zero_res;

  assign raw_re = wk_q.re[SwEff-1:0];
  assign raw_im = wk_q.im[SwEff-1:0];
  assign neg_re = raw_re[SwEff-1];
  assign neg_im = raw_im[SwEff-1];
  assign mag_re = neg_re ? (~raw_re + 1'b1) : raw_re;
  assign mag_im = neg_im ? (~raw_im + 1'b1) : raw_im;
  assign mul_b_re = wk_q.is_scale ? sf_q : 32'(mag_re);
  assign mul_b_im = wk_q.is_scale ? sf_q : 32'(mag_im);

  // volume multiply in two 32x32 halves
  assign sum64    = 64'(sum_q);
  assign vol_a    = (state_q == ST_VLO) ? sum64[31:0] : sum64[63:32];
  assign vol_prod = 64'(vol_a) * 64'(cfg_i.volume_element);

  // saturating accumulate
  always_comb begin
    acc_tot = 66'(sum_q) + 66'(prod_re_q);
    if (cfg_i.complex_mode) acc_tot = acc_tot + 66'(prod_im_q);
    acc_next = (acc_tot > 66'(AccMax)) ? ACC_WIDTH'(AccMax) : acc_tot[ACC_WIDTH-1:0];
  end

  always_comb begin
    norm_sum = {1'b0, vhi_q[47:0], 16'd0} + {17'd0, vlo_q[63:16]};
    if (vhi_q[63:48] != 16'd0 || norm_sum > {1'b0, AccMax}) norm_val = AccMax;
    else norm_val = norm_sum[63:0];
  end

  // one restoring division step
  always_comb begin
    rem_carry = rem_q[63];
    rem_sh    = {rem_q[62:0], (dcnt_q == '0)};
    rem_take  = rem_carry || (rem_sh >= norm_q);
    rem_next  = rem_take ? (rem_sh - norm_q) : rem_sh;
    quo_next  = {quo_q[62:0], rem_take};
  end

  // one integer square root step
  always_comb begin
    sq_try  = res_q + bit_q;
    sq_take = (x_q >= sq_try);
    x_next  = sq_take ? (x_q - sq_try) : x_q;
    res_next = sq_take ? ((res_q >> 1) + bit_q) : (res_q >> 1);
    if (over_q || res_next[63:32] != 32'd0) sf_final = 32'hFFFF_FFFF;
    else sf_final = res_next[31:0];
  end

  // scaled samples with saturation
  always_comb begin
    p_re = 64'(prod_re_q) >> 24;
    p_im = 64'(prod_im_q) >> 24;
    if (neg_re) scaled_re = 32'(64'd0 - ((p_re > NegLim) ? NegLim : p_re));
    else scaled_re = 32'((p_re > PosLim) ? PosLim : p_re);
    if (neg_im) scaled_im = 32'(64'd0 - ((p_im > NegLim) ? NegLim : p_im));
    else scaled_im = 32'((p_im > PosLim) ? PosLim : p_im);
    idx_top = (cfg_i.states_in_batch == 16'd0) ? 16'd0 : cfg_i.states_in_batch - 16'd1;

    point_res.out_real      = zero_seen_q ? 32'd0 : scaled_re;
    point_res.out_imag      = (zero_seen_q || !cfg_i.complex_mode) ? 32'd0 : scaled_im;
    point_res.norm_integral = 64'd0;
    point_res.status        = zero_seen_q ? StatusZero : StatusPoint;
    point_res.point_last    = wk_q.last;
    point_res.batch_end     = wk_q.last && (idx_q >= idx_top);

    norm_res               = '0;
    norm_res.norm_integral = norm_q;
    norm_res.status        = StatusNorm;
    zero_res               = '0;
    zero_res.status        = StatusZero;
  end

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          pop_o   = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_POST;
      ST_POST: begin
        if (wk_q.is_scale) state_d = ST_OUT;
        else if (wk_q.last) state_d = ST_VLO;
        else state_d = ST_IDLE;
      end
      ST_VLO:  state_d = ST_VHI;
      ST_VHI:  state_d = ST_VSUM;
      ST_VSUM: state_d = (norm_val == 64'd0) ? ST_OUT : ST_DIV;
      ST_DIV:  if (dcnt_q == DivCntW'(DivSteps - 1)) state_d = ST_SQRT;
      ST_SQRT: if (scnt_q == 5'd31) state_d = ST_OUT;
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sf_q        <= '0;
      zero_seen_q <= 1'b0;
      idx_q       <= '0;
      dcnt_q      <= '0;
      scnt_q      <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result or drop the one just taken
      if (state_q == ST_OUT && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_POST: begin
          if (!wk_q.is_scale) sum_q <= acc_next;
          else if (wk_q.last) begin
            if (idx_q >= idx_top) idx_q <= '0;
            else idx_q <= idx_q + 16'd1;
          end
        end
        ST_VSUM: begin
          sum_q  <= '0;
          dcnt_q <= '0;
          over_q <= 1'b0;
          if (norm_val == 64'd0) begin
            zero_seen_q <= 1'b1;
            sf_q        <= '0;
          end else begin
            zero_seen_q <= 1'b0;
          end
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          over_q <= over_q | quo_q[63];
          scnt_q <= '0;
        end
        ST_SQRT: begin
          scnt_q <= scnt_q + 5'd1;
          if (scnt_q == 5'd31) sf_q <= sf_final;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (item_valid_i) wk_q <= item_i;
      ST_MUL: begin
        prod_re_q <= ProdW'(mag_re) * ProdW'(mul_b_re);
        prod_im_q <= ProdW'(mag_im) * ProdW'(mul_b_im);
      end
      ST_POST: stage_q <= point_res;
      ST_VLO:  vlo_q <= vol_prod;
      ST_VHI:  vhi_q <= vol_prod;
      ST_VSUM: begin
        norm_q         <= norm_val;
        rem_q          <= '0;
        quo_q          <= '0;
        stage_q        <= zero_res;
      end
      ST_DIV: begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        x_q   <= quo_next;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      ST_SQRT: begin
        x_q   <= x_next;
        res_q <= res_next;
        bit_q <= bit_q >> 2;
        stage_q <= norm_res;
      end
      ST_OUT: if (slot_free) out_q <= stage_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hw/rtl/batched_state_vector_normalizer_unit.sv
// top level of the batched state vector normalizer
// depends on bsvn_pkg, bsvn_front, bsvn_back
//
// L2 normalizer for sampled state vectors, streamed twice per state. Accumulate
// points (tuser 0) add re^2 (and im^2 in complex mode) to a saturating sum; the
// accumulate point with tlast set gives one result carrying the norm integral
// (sum times volume element over 2^16) with status norm ready, or status zero norm. Scale
// points (tuser 1) each give one result: the point times 1/sqrt(norm), saturated,
// with tlast on the last point of a state and a batch-end flag on the last state.
// The front queues up to two input transfers so the input side keeps moving while
// the back works or the output stalls. The back handles one item at a time and takes
// no new item before it is through: a plain accumulate point passes pop, multiply and
// add; a scale point pop, multiply, scale and output, plus any output stall; and a last
// accumulate point also the two volume-multiply halves, the norm, the bit-serial division
// and the 32-step square root (both skipped on a zero norm). Configuration must be written
// only while no item is in flight; the block itself does not enforce this. Writes are always taken.
module batched_state_vector_normalizer_unit
  import bsvn_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 32,
  parameter int ACC_WIDTH    = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // real_part [31:0], imag_part [63:32]
  input  logic         s_axis_tuser,   // req_type
  input  logic         s_axis_tlast,   // last_point
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // out_real [31:0], out_imag [63:32], norm_integral [127:64]
  output logic [2:0]   m_axis_tuser,   // status [1:0], batch_end [2]
  output logic         m_axis_tlast,   // point_last
  // configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  cfg_t    cfg_q;
  logic    item_valid, pop;
  item_t   item;
  result_t res;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.complex_mode    <= 1'b1;
      cfg_q.volume_element  <= 32'd65536;
      cfg_q.states_in_batch <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COMPLEX_MODE: cfg_q.complex_mode    <= cfg_data_i[0];
        CFG_VOLUME:       cfg_q.volume_element  <= cfg_data_i;
        CFG_STATES:       cfg_q.states_in_batch <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bsvn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .data_i       (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (pop)
  );

  bsvn_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // result packing
  assign m_axis_tdata = {res.norm_integral, res.out_imag, res.out_real};
  assign m_axis_tuser = {res.batch_end, res.status};
  assign m_axis_tlast = res.point_last;

endmodule

FILE: hw/rtl/bsvn_chk.sv
// port-level checks of the batched state vector normalizer
// depends on bsvn_pkg and the top level it is bound to
module bsvn_chk
  import bsvn_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  a_status_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
    else $error("undefined status code");

  a_norm_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1:0] == StatusNorm) |-> (!m_axis_tlast && !m_axis_tuser[2]))
    else $error("norm result flagged as last point");

  a_batch_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tlast)
    else $error("batch end without last point");

  a_zero_norm_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1:0] == StatusZero) |-> (m_axis_tdata == 128'd0))
    else $error("zero norm result carries data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind batched_state_vector_normalizer_unit bsvn_chk u_bsvn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: test/tb_batched_state_vector_normalizer_unit.sv
// self-checking testbench of the batched state vector normalizer
// depends on bsvn_pkg and batched_state_vector_normalizer_unit
module tb_batched_state_vector_normalizer_unit;
  import bsvn_pkg::*;

  // expected-result store and predictor of the normalizer
  class norm_scoreboard;
    bit          cplx;
    logic [31:0] vol;
    logic [15:0] nstates;
    logic [63:0] sq_sum;
    logic [31:0] factor;
    bit          zero_seen;
    logic [15:0] st_idx;
    result_t     pending[$];
    int          errors;

    function new();
      cplx = 1; vol = 32'd65536; nstates = 16'd1;
      sq_sum = '0; factor = '0; zero_seen = 0; st_idx = '0; errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_COMPLEX_MODE: cplx = val[0];
        CFG_VOLUME:       vol = val;
        CFG_STATES:       nstates = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] magn(logic [31:0] s);
      return s[31] ? {32'd0, -s} : {32'd0, s};
    endfunction

    // saturating add of a square
    function logic [63:0] add_sq(logic [63:0] a, logic [31:0] s);
      logic [64:0] t;
      logic [63:0] m;
      m = magn(s);
      t = {1'b0, a} + {1'b0, m * m};
      return t[64] ? '1 : t[63:0];
    endfunction

    // floor(sqrt(2^96 / n)) saturated to 32 bits
    function logic [31:0] inv_root(logic [63:0] n);
      logic [127:0] q;
      logic [127:0] r;
      logic [127:0] b;
      q = (128'd1 << 96) / n;
      if (q[127:64] != 0) return '1;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        b = r | (128'd1 << i);
        if (b * b <= q) r = b;
      end
      return r > 128'hFFFF_FFFF ? '1 : r[31:0];
    endfunction

    function logic [31:0] scale(logic [31:0] s);
      logic [63:0] p;
      p = (magn(s) * factor) >> 24;
      if (s[31]) begin
        if (p > 64'h8000_0000) p = 64'h8000_0000;
        return -p[31:0];
      end
      if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
      return p[31:0];
    endfunction

    function void note_input(item_t it);
      result_t r;
      logic [95:0] prod;
      logic [63:0] nrm;
      r = '0;
      if (!it.is_scale) begin
        sq_sum = add_sq(sq_sum, it.re);
        if (cplx) sq_sum = add_sq(sq_sum, it.im);
        if (!it.last) return;
        prod = sq_sum * vol;
        nrm = (prod[95:80] != 0) ? '1 : prod[79:16];
        sq_sum = '0;
        r.norm_integral = nrm;
        if (nrm == 0) begin
          zero_seen = 1; factor = '0; r.status = StatusZero;
        end else begin
          zero_seen = 0; factor = inv_root(nrm); r.status = StatusNorm;
        end
      end else begin
        if (!zero_seen) begin
          r.out_real = scale(it.re);
          if (cplx) r.out_imag = scale(it.im);
        end
        r.status = zero_seen ? StatusZero : StatusPoint;
        if (it.last) begin
          r.point_last = 1;
          if (st_idx >= ((nstates == 0) ? 16'd0 : nstates - 16'd1)) begin
            r.batch_end = 1; st_idx = '0;
          end else st_idx = st_idx + 16'd1;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_real !== e.out_real)
        $display("%0t: out_real exp %h got %h", $time, e.out_real, got.out_real);
      if (got.out_imag !== e.out_imag)
        $display("%0t: out_imag exp %h got %h", $time, e.out_imag, got.out_imag);
      if (got.norm_integral !== e.norm_integral)
        $display("%0t: norm exp %h got %h", $time, e.norm_integral, got.norm_integral);
      if (got.status !== e.status)
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
      if (got.point_last !== e.point_last)
        $display("%0t: point_last exp %b got %b", $time, e.point_last, got.point_last);
      if (got.batch_end !== e.batch_end)
        $display("%0t: batch_end exp %b got %b", $time, e.batch_end, got.batch_end);
      if (got !== e) errors++;
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [127:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  norm_scoreboard sb = new();
  longint cycles = 0;

  batched_state_vector_normalizer_unit u_top (.*);

  always #2 clk_i = ~clk_i;

  // half no gap, most others short, a few long ones
  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result({m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[127:64],
                         m_axis_tuser[1:0], m_axis_tlast, m_axis_tuser[2]});
      m_axis_tready <= (gap_len() == 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // watchdog: limit is the slowest item plus stalls, taken many times over
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("tb_batched_state_vector_normalizer_unit NOT OK");
      $finish;
    end
  end

  // valid stays high after the transfer; the next write or send takes it over
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // one input transfer, with a random gap before it; valid stays high after it
  task automatic send_point(bit is_scale, logic [31:0] re, logic [31:0] im, bit last);
    item_t it;
    int    g;
    cfg_valid_i <= 0;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= is_scale;
    s_axis_tdata  <= {im, re};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    it.is_scale = is_scale; it.last = last; it.re = re; it.im = im;
    sb.note_input(it);
  endtask

  // wait for all results, then let a last accumulate point settle
  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 255) - 128;
      3: return $urandom() >>> $urandom_range(4, 16);
      default: return $urandom();
    endcase
  endfunction

  // one state: accumulate pass then scale pass over the same points
  task automatic run_state(int npts);
    logic [31:0] re[$];
    logic [31:0] im[$];
    for (int i = 0; i < npts; i++) begin
      re.push_back(rand_sample());
      im.push_back(rand_sample());
    end
    for (int i = 0; i < npts; i++) send_point(0, re[i], im[i], i == npts - 1);
    for (int i = 0; i < npts; i++) send_point(1, re[i], im[i], i == npts - 1);
  endtask

  initial begin
    int sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, zero norm, tiny norm, states counter
    write_reg(CFG_STATES, 32'd0);
    send_point(0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_point(0, 32'h8000_0000, 32'h8000_0000, 1);
    send_point(1, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_point(0, 32'd0, 32'd0, 1);
    send_point(1, 32'h1234_5678, 32'hFFFF_FFFF, 1);
    send_point(0, 32'd1, 32'd0, 1);
    send_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_point(1, 32'd1, 32'hFFFF_FFFF, 1);
    drain();
    write_reg(CFG_COMPLEX_MODE, 32'd0);
    write_reg(CFG_VOLUME, 32'hFFFF_FFFF);
    write_reg(CFG_STATES, 32'd3);
    send_point(0, 32'h0100_0000, 32'hDEAD_BEEF, 1);
    send_point(1, 32'hFF00_0000, 32'hDEAD_BEEF, 1);
    send_point(0, 32'h0000_0010, 32'd5, 1);
    send_point(1, 32'h0100_0000, 32'd5, 1);
    drain();
    write_reg(CFG_VOLUME, 32'd1);
    send_point(0, 32'd1, 32'd0, 1);
    send_point(1, 32'd1, 32'd0, 1);
    drain();

    // random phases over several settings
    sent = 0;
    for (int ph = 0; sent < 650; ph++) begin
      write_reg(CFG_COMPLEX_MODE, $urandom_range(0, 1));
      case (ph % 4)
        0: write_reg(CFG_VOLUME, 32'd65536);
        1: write_reg(CFG_VOLUME, $urandom_range(1, 32'hFFFF_FFFF));
        2: write_reg(CFG_VOLUME, 32'hFFFF_FFFF);
        default: write_reg(CFG_VOLUME, $urandom_range(1, 300));
      endcase
      write_reg(CFG_STATES, (ph % 5 == 4) ? 32'hFFFF : $urandom_range(0, 4));
      for (int s = 0; s < 8; s++) begin
        int n;
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          send_point($urandom_range(0, 1), rand_sample(), rand_sample(),
                     $urandom_range(0, 1));
          sent += 1;
        end else begin
          run_state(n);
          sent += 2 * n;
        end
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_batched_state_vector_normalizer_unit OK");
    else
      $display("tb_batched_state_vector_normalizer_unit NOT OK");
    $finish;
  end

endmodule
